// ===== hdl/usbsx_pkg.sv =====
// Shared types and constants for the USB-MIDI SysEx reassembler.
package usbsx_pkg;

  // USB-MIDI code index numbers
  localparam logic [3:0] CIN_SYSEX  = 4'h4;
  localparam logic [3:0] CIN_END1   = 4'h5;
  localparam logic [3:0] CIN_END2   = 4'h6;
  localparam logic [3:0] CIN_END3   = 4'h7;
  localparam logic [3:0] CIN_CC     = 4'hB;
  localparam logic [3:0] CIN_SINGLE = 4'hF;

  // MIDI byte values
  localparam logic [7:0] SYSEX_SOX   = 8'hF0;
  localparam logic [7:0] END_EXCL    = 8'hF7;
  localparam logic [3:0] CC_STATUS_HI = 4'hB;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_CC       = 2'd1,
    KIND_INVALID  = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  // Command classes handed from the front end to the back end
  typedef enum logic [1:0] {
    OP_SYSEX  = 2'd0,
    OP_END    = 2'd1,
    OP_SINGLE = 2'd2,
    OP_CC     = 2'd3
  } op_t;

  // One classified packet
  typedef struct packed {
    op_t             op;
    logic [1:0]      cnt;        // bytes carried: 1..3
    logic [2:0][7:0] data;       // packet bytes 1..3
    logic            end_ok;     // last carried byte is end of exclusive
    logic            b0_eox;     // first byte is end of exclusive
    logic            b0_status;  // first byte has the status bit set
    logic            cc_ok;      // first byte is a control change status
  } cmd_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_APPEND,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_RESULT
  } state_t;

endpackage

// ===== hdl/usbsx_front.sv =====
// Front end: accepts packets and decodes them into back end commands.
module usbsx_front import usbsx_pkg::*; (
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // header, first, second, third byte
  input  logic        q_full,
  output logic        push,
  output cmd_t        cmd
);

  logic [3:0] cin;
  logic       known;

  assign cin      = s_tdata[3:0];
  assign s_tready = !q_full;

  // Decode code index; unknown indices are taken and dropped
  always_comb begin
    cmd.data      = s_tdata[31:8];
    cmd.b0_eox    = (s_tdata[15:8] == END_EXCL);
    cmd.b0_status = s_tdata[15];
    cmd.cc_ok     = (s_tdata[15:12] == CC_STATUS_HI);
    cmd.op        = OP_SYSEX;
    cmd.cnt       = 2'd3;
    cmd.end_ok    = 1'b0;
    known         = 1'b1;
    unique case (cin)
      CIN_SYSEX: begin
        cmd.op = OP_SYSEX;
      end
      CIN_END1: begin
        cmd.op     = OP_END;
        cmd.cnt    = 2'd1;
        cmd.end_ok = (s_tdata[15:8] == END_EXCL);
      end
      CIN_END2: begin
        cmd.op     = OP_END;
        cmd.cnt    = 2'd2;
        cmd.end_ok = (s_tdata[23:16] == END_EXCL);
      end
      CIN_END3: begin
        cmd.op     = OP_END;
        cmd.cnt    = 2'd3;
        cmd.end_ok = (s_tdata[31:24] == END_EXCL);
      end
      CIN_CC: begin
        cmd.op = OP_CC;
      end
      CIN_SINGLE: begin
        cmd.op  = OP_SINGLE;
        cmd.cnt = 2'd1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign push = s_tvalid && !q_full && known;

endmodule

// ===== hdl/usbsx_queue.sv =====
// Two-entry command queue between front end and back end.
module usbsx_queue import usbsx_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_cmd
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign pop_cmd = entry[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/usbsx_back.sv =====
// Back end: message store, fill count, checks and result emission.
module usbsx_back import usbsx_pkg::*; #(
  parameter int STORE_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int CW = $clog2(STORE_BYTES + 1);
  localparam logic [CW:0] STORE_EXT = (CW + 1)'(STORE_BYTES);

  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    rd_data;

  state_t        state, state_next;
  cmd_t          cmd;
  logic [CW-1:0] fill, fill_next;
  logic [AW-1:0] idx, idx_next;
  logic [1:0]    app_k, app_k_next;
  logic          emit_after, emit_after_next;
  kind_t         res_kind, res_kind_next;
  logic          sox_ok;

  logic          out_valid;
  kind_t         out_kind;
  logic [7:0]    out_byte;
  logic [AW-1:0] out_idx;
  logic          out_last;
  logic [7:0]    out_s, out_n, out_v;
  logic          out_free;
  logic          load_res, load_byte;

  logic          wr_en;
  logic [7:0]    wr_byte;
  logic [CW:0]   fill_plus;
  logic          is_last;

  assign out_free  = !out_valid || m_tready;
  assign wr_byte   = cmd.data[app_k];
  assign fill_plus = {1'b0, fill} + (CW + 1)'(cmd.cnt);
  assign is_last   = (CW'(idx) + CW'(1)) == fill;

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd <= q_cmd;
    idx        <= idx_next;
    app_k      <= app_k_next;
    emit_after <= emit_after_next;
    res_kind   <= res_kind_next;
  end

  // Next state and control
  always_comb begin
    state_next      = state;
    fill_next       = fill;
    idx_next        = idx;
    app_k_next      = app_k;
    emit_after_next = emit_after;
    res_kind_next   = res_kind;
    q_pop           = 1'b0;
    wr_en           = 1'b0;
    load_res        = 1'b0;
    load_byte       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        app_k_next = 2'd0;
        idx_next   = '0;
        state_next = ST_IDLE;
        unique case (cmd.op)
          OP_SYSEX: begin
            if (fill_plus > STORE_EXT) begin
              res_kind_next = KIND_OVERFLOW;
              state_next    = ST_RESULT;
            end else begin
              emit_after_next = 1'b0;
              state_next      = ST_APPEND;
            end
          end
          OP_END: begin
            if (fill < CW'(3) || !sox_ok || !cmd.end_ok) begin
              res_kind_next = KIND_INVALID;
              state_next    = ST_RESULT;
            end else if (fill_plus > STORE_EXT) begin
              res_kind_next = KIND_OVERFLOW;
              state_next    = ST_RESULT;
            end else begin
              emit_after_next = 1'b1;
              state_next      = ST_APPEND;
            end
          end
          OP_SINGLE: begin
            if (cmd.b0_status && !(cmd.b0_eox && fill > CW'(2))) begin
              // real-time or other status byte: ignored
              state_next = ST_IDLE;
            end else if (fill > CW'(2)) begin
              if ({1'b0, fill} >= STORE_EXT) begin
                res_kind_next = KIND_OVERFLOW;
                state_next    = ST_RESULT;
              end else begin
                emit_after_next = cmd.b0_eox;
                state_next      = ST_APPEND;
              end
            end else begin
              fill_next = '0;
            end
          end
          OP_CC: begin
            if (cmd.cc_ok) begin
              res_kind_next = KIND_CC;
              state_next    = ST_RESULT;
            end else begin
              fill_next = '0;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_APPEND: begin
        wr_en      = 1'b1;
        fill_next  = fill + CW'(1);
        app_k_next = app_k + 2'd1;
        if (app_k_next == cmd.cnt) begin
          state_next = emit_after ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          load_byte = 1'b1;
          if (is_last) begin
            fill_next  = '0;
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = ST_EMIT_RD;
          end
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          load_res = 1'b1;
          if (res_kind != KIND_CC) fill_next = '0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Message store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[fill[AW-1:0]] <= wr_byte;
    rd_data <= mem[idx];
  end

  // Start-of-exclusive flag for entry zero
  always_ff @(posedge clk) begin
    if (wr_en && fill == '0) sox_ok <= (wr_byte == SYSEX_SOX);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_res || load_byte) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      out_kind <= KIND_BYTE;
      out_byte <= rd_data;
      out_idx  <= idx;
      out_last <= is_last;
      out_s    <= 8'd0;
      out_n    <= 8'd0;
      out_v    <= 8'd0;
    end else if (load_res) begin
      out_kind <= res_kind;
      out_byte <= 8'd0;
      out_idx  <= '0;
      out_last <= 1'b0;
      out_s    <= (res_kind == KIND_CC) ? cmd.data[0] : 8'd0;
      out_n    <= (res_kind == KIND_CC) ? cmd.data[1] : 8'd0;
      out_v    <= (res_kind == KIND_CC) ? cmd.data[2] : 8'd0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {2'b00, out_v, out_n, out_s, 6'(out_idx), out_byte};

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, fill} <= STORE_EXT)
    else $error("fill count beyond store size");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    state == ST_APPEND |-> {1'b0, fill} < STORE_EXT)
    else $error("append into a full store");

  a_last_is_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_kind == KIND_BYTE)
    else $error("last flag on a non-message result");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    load_byte && is_last |=> fill == '0)
    else $error("fill count not cleared after message");

endmodule

// ===== hdl/usb_midi_sysex_reassembler.sv =====
// Top level of the USB-MIDI SysEx reassembler.
//
//  channel  dir  beat                    fields (lowest bit up)
//  s_*      in   one USB-MIDI packet     tdata: header, first, second, third byte
//  m_*      out  one result              tdata: message_byte, byte_index, cc_status,
//                                               cc_number, cc_value; tuser: result_kind;
//                                               tlast: last_of_message
//
// A packet passes ST_IDLE and ST_EXEC when ignored or rejected, adds ST_RESULT for a single
// result and ST_APPEND for each byte carried on an append; a message then leaves through
// ST_EMIT_RD and ST_EMIT_OUT for each byte, set by the registered read of the message store.
// A two-entry command queue lets packets be taken while a message drains.
// rst is synchronous and clears the queue, the sequencer and the fill count.
// A stalled m_tready holds the result; the back end waits, the queue fills.
module usb_midi_sysex_reassembler import usbsx_pkg::*; #(
  parameter int STORE_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // header_byte, first_byte, second_byte, third_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // message_byte, byte_index, cc_status, cc_number,
                                 // cc_value, zero pad
  output logic [1:0]  m_tuser,   // result_kind
  output logic        m_tlast
);

  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, pop_cmd;

  usbsx_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (q_push),
    .cmd      (push_cmd)
  );

  usbsx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  usbsx_back #(.STORE_BYTES(STORE_BYTES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== sim/usbsx_checker.sv =====
// Reassembler checker: predicts the results of each packet beat and compares them on m_*.
module usbsx_checker import usbsx_pkg::*; #(
  parameter int STORE_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // header_byte, first_byte, second_byte, third_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // message_byte, byte_index, cc_status, cc_number,
                                 // cc_value, zero pad
  input  logic [1:0]  m_tuser,   // result_kind
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending_results,
  output int          results_checked,
  output int          messages_done
);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] msg_byte;
    logic [5:0] byte_pos;
    logic       last;
    logic [7:0] cc_status;
    logic [7:0] cc_number;
    logic [7:0] cc_value;
  } result_t;

  // shadow copy of the message store and its fill level
  logic [7:0] sx_store [STORE_BYTES];
  int         sx_fill = 0;
  result_t    due_beats [$];
  int         mismatches = 0;
  int         checked = 0;
  int         completed = 0;

  task automatic push_result(input kind_t kind, input logic [7:0] msg_byte,
                             input logic [5:0] byte_pos, input logic last,
                             input logic [7:0] cc_status, input logic [7:0] cc_number,
                             input logic [7:0] cc_value);
    result_t r;
    r.kind      = kind;
    r.msg_byte  = msg_byte;
    r.byte_pos  = byte_pos;
    r.last      = last;
    r.cc_status = cc_status;
    r.cc_number = cc_number;
    r.cc_value  = cc_value;
    due_beats.push_back(r);
  endtask

  // error result always empties the message
  task automatic reject_message(input kind_t kind);
    sx_fill = 0;
    push_result(kind, 8'h00, 6'd0, 1'b0, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic append_byte(input logic [7:0] value);
    sx_store[sx_fill] = value;
    sx_fill++;
  endtask

  task automatic emit_message();
    for (int i = 0; i < sx_fill; i++)
      push_result(KIND_BYTE, sx_store[i], i[5:0], (i == sx_fill - 1), 8'h00, 8'h00, 8'h00);
    sx_fill = 0;
    completed++;
  endtask

  // expected results of one USB-MIDI packet
  task automatic predict_packet(input logic [31:0] pkt);
    logic [3:0]      cin;
    logic [2:0][7:0] pb;
    int              cnt;
    cin = pkt[3:0];
    pb  = pkt[31:8];
    case (cin)
      CIN_SINGLE: begin
        if (pb[0] == END_EXCL && sx_fill > 2) begin
          // end of exclusive on its own: no start check
          if (sx_fill >= STORE_BYTES) begin
            reject_message(KIND_OVERFLOW);
          end else begin
            append_byte(pb[0]);
            emit_message();
          end
        end else if (pb[0][7]) begin
          // real-time or other status byte: ignored
        end else if (sx_fill > 2) begin
          if (sx_fill >= STORE_BYTES) reject_message(KIND_OVERFLOW);
          else append_byte(pb[0]);
        end else begin
          sx_fill = 0;
        end
      end
      CIN_END1, CIN_END2, CIN_END3: begin
        cnt = cin - CIN_END1 + 1;
        if (sx_fill < 3 || sx_store[0] != SYSEX_SOX || pb[cnt-1] != END_EXCL) begin
          reject_message(KIND_INVALID);
        end else if (sx_fill + cnt > STORE_BYTES) begin
          reject_message(KIND_OVERFLOW);
        end else begin
          for (int i = 0; i < cnt; i++) append_byte(pb[i]);
          emit_message();
        end
      end
      CIN_SYSEX: begin
        if (sx_fill + 3 > STORE_BYTES) begin
          reject_message(KIND_OVERFLOW);
        end else begin
          for (int i = 0; i < 3; i++) append_byte(pb[i]);
        end
      end
      CIN_CC: begin
        if (pb[0][7:4] != CC_STATUS_HI) sx_fill = 0;
        else push_result(KIND_CC, 8'h00, 6'd0, 1'b0, pb[0], pb[1], pb[2]);
      end
      default: begin
        // other code indices carry nothing for us
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (due_beats.size() == 0) begin
      $error("result beat with nothing expected: kind %0d data 0x%0h", m_tuser, m_tdata);
      mismatches++;
    end else begin
      want = due_beats.pop_front();
      checked++;
      check_field("result_kind", want.kind, m_tuser);
      check_field("message_byte", want.msg_byte, m_tdata[7:0]);
      check_field("byte_index", want.byte_pos, m_tdata[13:8]);
      check_field("last_of_message", want.last, m_tlast);
      check_field("cc_status", want.cc_status, m_tdata[21:14]);
      check_field("cc_number", want.cc_number, m_tdata[29:22]);
      check_field("cc_value", want.cc_value, m_tdata[37:30]);
    end
  endtask

  // results first: nothing leaves on the edge its packet arrives
  always @(posedge clk) begin
    if (rst) begin
      sx_fill = 0;
      due_beats.delete();
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) predict_packet(s_tdata);
    end
    fail_count      <= mismatches;
    pending_results <= due_beats.size();
    results_checked <= checked;
    messages_done   <= completed;
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the USB-MIDI SysEx reassembler: packet stimulus and verdict.
module tb;
  import usbsx_pkg::*;

  localparam int STORE_BYTES   = 64;
  localparam int RANDOM_ITEMS  = 290;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic        m_tready = 1'b1;
  logic        s_tready;
  logic        m_tvalid;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int fail_count;
  int pending_results;
  int results_checked;
  int messages_done;
  int packets_sent = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;

  usb_midi_sysex_reassembler #(.STORE_BYTES(STORE_BYTES)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  usbsx_checker #(.STORE_BYTES(STORE_BYTES)) msg_check (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .m_tlast         (m_tlast),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_checked (results_checked),
    .messages_done   (messages_done)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side back-pressure in short bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  // header with a random cable number
  function automatic logic [7:0] hdr(input logic [3:0] cin);
    logic [3:0] cable;
    cable = 4'($urandom_range(0, 15));
    return {cable, cin};
  endfunction

  // one packet beat, with an optional gap in front
  task automatic send_packet(input logic [7:0] header, input logic [7:0] b0,
                             input logic [7:0] b1, input logic [7:0] b2);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b2, b1, b0, header};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    packets_sent++;
  endtask

  // mostly well-formed message with random content, length and ending
  task automatic send_message();
    int              n_sysex;
    int              n_data;
    int              ending;
    int              k;
    logic [7:0]      rt;
    logic [2:0][7:0] eb;
    n_sysex = ($urandom_range(0, 9) == 0) ? $urandom_range(19, 22) : $urandom_range(1, 4);
    send_packet(hdr(CIN_SYSEX), ($urandom_range(0, 9) == 0) ? rnd8() : SYSEX_SOX,
                rnd8(), rnd8());
    for (int i = 1; i < n_sysex; i++) begin
      // harmless traffic mixed into the message
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          send_packet(hdr(CIN_CC), {CC_STATUS_HI, 4'($urandom_range(0, 15))}, rnd8(), rnd8());
        end else begin
          rt = 8'($urandom_range(128, 255));
          if (rt == END_EXCL) rt = 8'hF8;
          send_packet(hdr(CIN_SINGLE), rt, rnd8(), rnd8());
        end
      end
      send_packet(hdr(CIN_SYSEX), rnd8(), rnd8(), rnd8());
    end
    n_data = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    for (int i = 0; i < n_data; i++)
      send_packet(hdr(CIN_SINGLE), 8'($urandom_range(0, 127)), rnd8(), rnd8());
    ending = $urandom_range(0, 9);
    if (ending <= 5 || ending == 8) begin
      k = (ending == 8) ? $urandom_range(0, 2) : ending / 2;
      eb = {rnd8(), rnd8(), rnd8()};
      eb[k] = (ending == 8) ? rnd8() : END_EXCL;
      send_packet(hdr(CIN_END1 + 4'(k)), eb[0], eb[1], eb[2]);
    end else if (ending <= 7) begin
      send_packet(hdr(CIN_SINGLE), END_EXCL, rnd8(), rnd8());
    end
  endtask

  initial begin
    int base;
    int sel;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // complete messages with each kind of end packet, cable bits set
    send_packet(8'h04, 8'hF0, 8'h7E, 8'h01);
    send_packet(8'h07, 8'h02, 8'h03, 8'hF7);
    send_packet(8'hF4, 8'hF0, 8'h00, 8'h20);
    send_packet(8'h35, 8'hF7, 8'h00, 8'h00);
    send_packet(8'h04, 8'hF0, 8'h01, 8'h02);
    send_packet(8'h06, 8'h03, 8'hF7, 8'hFF);
    // control change pass-through, extremes of the data bytes
    send_packet(8'h0B, 8'hB5, 8'h07, 8'h7F);
    send_packet(8'hFB, 8'hBF, 8'hFF, 8'hFF);
    send_packet(8'h0B, 8'hB0, 8'h00, 8'h00);
    // non-CC status on the CC code index drops the message, end is then invalid
    send_packet(8'h04, 8'hF0, 8'h11, 8'h22);
    send_packet(8'h0B, 8'h90, 8'h40, 8'h40);
    send_packet(8'h05, 8'hF7, 8'h00, 8'h00);
    // bad start byte, then bad end byte
    send_packet(8'h04, 8'h00, 8'h01, 8'h02);
    send_packet(8'h05, 8'hF7, 8'h00, 8'h00);
    send_packet(8'h04, 8'hF0, 8'h01, 8'h02);
    send_packet(8'h07, 8'h01, 8'h02, 8'h03);
    // single-byte data, real-time byte in between, single-byte end
    send_packet(8'h04, 8'hF0, 8'h01, 8'h02);
    send_packet(8'h0F, 8'h55, 8'h00, 8'h00);
    send_packet(8'h0F, 8'hF8, 8'h00, 8'h00);
    send_packet(8'h0F, 8'hF7, 8'h00, 8'h00);
    // single-byte end emits without a start check
    send_packet(8'h04, 8'h12, 8'h34, 8'h56);
    send_packet(8'hFF, 8'hF7, 8'hFF, 8'hFF);
    // data byte or end byte with no message open, ignored code indices
    send_packet(8'h0F, 8'h33, 8'h00, 8'h00);
    send_packet(8'h0F, 8'hF7, 8'h00, 8'h00);
    send_packet(8'h00, 8'h00, 8'h00, 8'h00);
    send_packet(8'h08, 8'h80, 8'h40, 8'h40);

    // random traffic: gaps and back-pressure off for a stretch in the middle and at the end
    base = packets_sent;
    while (packets_sent < base + RANDOM_ITEMS) begin
      idle_on = (packets_sent < base + 100 || packets_sent >= base + 140) &&
                packets_sent < base + 220;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        send_message();
      end else if (sel < 85) begin
        send_packet(hdr(CIN_CC), ($urandom_range(0, 9) < 7) ?
                    {CC_STATUS_HI, 4'($urandom_range(0, 15))} : rnd8(), rnd8(), rnd8());
      end else begin
        send_packet(rnd8(), rnd8(), rnd8(), rnd8());
      end
    end
    idle_on = 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d packets; checked %0d result beats, %0d SysEx messages reassembled.",
             packets_sent, results_checked, messages_done);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== usb_midi_sysex_reassembler.f =====
hdl/usbsx_pkg.sv
hdl/usbsx_front.sv
hdl/usbsx_queue.sv
hdl/usbsx_back.sv
hdl/usb_midi_sysex_reassembler.sv
sim/usbsx_checker.sv
sim/tb.sv
